### src/mmpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_pkg
// Shared types, widths and helpers of the min/max peak decimator.
// ----------------------------------------------------------------------------
package mmpd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SPP_W   = 16;
  localparam int BL_W    = 13;
  localparam int N_W     = 24;
  localparam int SPAN_W  = SPP_W + BL_W;
  localparam int DIV_CNT_W = $clog2(N_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = N_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPP         = 2'd0,
    REG_BUCKET_LIM  = 2'd1,
    REG_AVAILABLE   = 2'd2,
    REG_RIGHT_ALIGN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SPP_W-1:0] spp;
    logic [BL_W-1:0]  bucket_limit;
    logic [N_W-1:0]   available;
    logic             right_align;
  } cfg_t;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [SPP_W-1:0] rem;
  } span_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_CLAMP,
    ST_DIV
  } pre_st_t;

  function automatic logic [SPP_W-1:0] eff_spp(input logic [SPP_W-1:0] spp);
    eff_spp = (spp == '0) ? SPP_W'(1) : spp;
  endfunction

endpackage

### src/min_max_peak_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_peak_decimator
// Waveform peak decimator: reduces each bucket of samples to a min/max pair.
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_tready is high and emits a min/max
// beat at the end of every bucket, with tlast on the final bucket of a run;
// a sample with tuser set opens a run of n = min(bucket_limit *
// samples_per_bucket, available_samples) samples. Each sample goes through
// one compare-and-count stage into a result register backed by a skid stage,
// so input keeps flowing while out_tready is low for a beat. After any config
// write in_tready drops while the run span is recomputed: the limit*spp
// multiply, then the clamp, then the bit-serial n mod spp for right alignment.
// ----------------------------------------------------------------------------
module min_max_peak_decimator #(
  parameter int SAMPLE_BITS = mmpd_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_W-1:0]                     in_tdata,   // sample
  input  logic                                in_tuser,   // first_of_run
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_W-1:0]                    out_tdata,  // bucket_min, bucket_max
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mmpd_pkg::cfg_t  cfg;
  mmpd_pkg::span_t span;
  logic            busy, can_push, accept, res_valid, res_last;
  logic signed [SAMPLE_BITS-1:0] sample, res_min, res_max;
  logic [SAMPLE_BITS-1:0] o_min, o_max;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy && can_push;
  assign accept    = in_tvalid && in_tready;
  assign sample    = in_tdata[SAMPLE_BITS-1:0];

  mmpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg),
    .span    (span),
    .busy    (busy)
  );

  mmpd_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .span         (span),
    .accept       (accept),
    .sample       (sample),
    .first_of_run (in_tuser),
    .res_valid    (res_valid),
    .res_min      (res_min),
    .res_max      (res_max),
    .res_last     (res_last)
  );

  mmpd_obuf #(.SAMPLE_BITS(SAMPLE_BITS)) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_min  (res_min),
    .push_max  (res_max),
    .push_last (res_last),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_min   (o_min),
    .out_max   (o_max),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_W'({o_max, o_min});

endmodule

### src/mmpd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_cfg
// Config registers plus the run span precompute: n = min(limit*spp, avail)
// and n mod spp by a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmpd_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]       wr_idx,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]      wr_data,
  output mmpd_pkg::cfg_t                       cfg,
  output mmpd_pkg::span_t                      span,
  output logic                                 busy
);

  mmpd_pkg::cfg_t   cfg_r;
  mmpd_pkg::pre_st_t st_r, st_nxt;

  logic [mmpd_pkg::SPAN_W-1:0]    span_r;
  logic [mmpd_pkg::N_W-1:0]       n_r;
  logic [mmpd_pkg::N_W-1:0]       dvd_r;
  logic [mmpd_pkg::SPP_W-1:0]     rem_r;
  logic [mmpd_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [mmpd_pkg::SPP_W-1:0]     espp;
  logic [mmpd_pkg::SPP_W:0]       trial;
  logic [mmpd_pkg::SPP_W-1:0]     rem_step;
  logic [mmpd_pkg::N_W-1:0]       n_clamp;
  logic                           div_last;

  assign espp     = mmpd_pkg::eff_spp(cfg_r.spp);
  assign trial    = {rem_r, dvd_r[mmpd_pkg::N_W-1]};
  assign rem_step = (trial >= {1'b0, espp}) ? mmpd_pkg::SPP_W'(trial - {1'b0, espp})
                                            : trial[mmpd_pkg::SPP_W-1:0];
  assign n_clamp  = (span_r < mmpd_pkg::SPAN_W'(cfg_r.available))
                    ? span_r[mmpd_pkg::N_W-1:0] : cfg_r.available;
  assign div_last = (cnt_r == mmpd_pkg::DIV_CNT_W'(mmpd_pkg::N_W - 1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mmpd_pkg::ST_IDLE:  st_nxt = mmpd_pkg::ST_IDLE;
      mmpd_pkg::ST_SPAN:  st_nxt = mmpd_pkg::ST_CLAMP;
      mmpd_pkg::ST_CLAMP: st_nxt = mmpd_pkg::ST_DIV;
      mmpd_pkg::ST_DIV:   st_nxt = div_last ? mmpd_pkg::ST_IDLE : mmpd_pkg::ST_DIV;
      default:            st_nxt = mmpd_pkg::ST_IDLE;
    endcase
    if (wr_en) begin
      st_nxt = mmpd_pkg::ST_SPAN;
    end
  end

  always_comb begin
    busy = (st_r != mmpd_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r                <= mmpd_pkg::ST_IDLE;
      cfg_r.spp           <= mmpd_pkg::SPP_W'(1);
      cfg_r.bucket_limit  <= mmpd_pkg::BL_W'(1);
      cfg_r.available     <= '0;
      cfg_r.right_align   <= 1'b0;
      n_r                 <= '0;
      rem_r               <= '0;
      cnt_r               <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) begin
        unique case (mmpd_pkg::reg_idx_t'(wr_idx))
          mmpd_pkg::REG_SPP:         cfg_r.spp <= wr_data[mmpd_pkg::SPP_W-1:0];
          mmpd_pkg::REG_BUCKET_LIM:  cfg_r.bucket_limit <= wr_data[mmpd_pkg::BL_W-1:0];
          mmpd_pkg::REG_AVAILABLE:   cfg_r.available <= wr_data[mmpd_pkg::N_W-1:0];
          mmpd_pkg::REG_RIGHT_ALIGN: cfg_r.right_align <= wr_data[0];
          default: ;
        endcase
      end
      case (st_r)
        mmpd_pkg::ST_CLAMP: begin
          n_r   <= n_clamp;
          rem_r <= '0;
          cnt_r <= '0;
        end
        mmpd_pkg::ST_DIV: begin
          rem_r <= rem_step;
          cnt_r <= cnt_r + mmpd_pkg::DIV_CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      mmpd_pkg::ST_SPAN:  span_r <= mmpd_pkg::SPAN_W'(cfg_r.bucket_limit) *
                                    mmpd_pkg::SPAN_W'(espp);
      mmpd_pkg::ST_CLAMP: dvd_r  <= n_clamp;
      mmpd_pkg::ST_DIV:   dvd_r  <= {dvd_r[mmpd_pkg::N_W-2:0], 1'b0};
      default: ;
    endcase
  end

  assign cfg      = cfg_r;
  assign span.n   = n_r;
  assign span.rem = rem_r;

endmodule

### src/mmpd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_core
// Bucket tracking and running min/max update, one sample per beat.
// ----------------------------------------------------------------------------
module mmpd_core #(
  parameter int SAMPLE_BITS = mmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmpd_pkg::cfg_t                cfg,
  input  mmpd_pkg::span_t               span,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          first_of_run,
  output logic                          res_valid,
  output logic signed [SAMPLE_BITS-1:0] res_min,
  output logic signed [SAMPLE_BITS-1:0] res_max,
  output logic                          res_last
);

  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [mmpd_pkg::SPP_W-1:0]    pos_r, pos_nxt, size_r, size_nxt;
  logic [mmpd_pkg::N_W-1:0]      remain_r, remain_nxt;

  logic [mmpd_pkg::SPP_W-1:0]    espp, start_size, size_e, pos_e, pos_inc;
  logic [mmpd_pkg::N_W-1:0]      rem_e, rem_dec;
  logic                          active, done, last;

  function automatic logic [mmpd_pkg::SPP_W-1:0] clip_size(
    input logic [mmpd_pkg::SPP_W-1:0] s,
    input logic [mmpd_pkg::N_W-1:0]   n
  );
    clip_size = (n < mmpd_pkg::N_W'(s)) ? n[mmpd_pkg::SPP_W-1:0] : s;
  endfunction

  always_comb begin
    espp       = mmpd_pkg::eff_spp(cfg.spp);
    start_size = (cfg.right_align && span.rem != '0) ? span.rem : clip_size(espp, span.n);
    rem_e      = first_of_run ? span.n : remain_r;
    pos_e      = first_of_run ? '0 : pos_r;
    size_e     = first_of_run ? start_size : size_r;
    active     = (rem_e != '0);
    rem_dec    = rem_e - mmpd_pkg::N_W'(1);
    pos_inc    = pos_e + mmpd_pkg::SPP_W'(1);
    last       = (rem_dec == '0);
    done       = (pos_inc >= size_e) || last;

    min_nxt    = (pos_e == '0 || sample < min_r) ? sample : min_r;
    max_nxt    = (pos_e == '0 || sample > max_r) ? sample : max_r;

    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    if (accept) begin
      remain_nxt = rem_e;
      pos_nxt    = pos_e;
      size_nxt   = size_e;
      if (active) begin
        remain_nxt = rem_dec;
        pos_nxt    = done ? '0 : pos_inc;
        if (done) begin
          size_nxt = last ? '0 : clip_size(espp, rem_dec);
        end
      end
    end

    res_valid = accept && active && done;
    res_min   = min_nxt;
    res_max   = max_nxt;
    res_last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
      pos_r    <= '0;
      size_r   <= '0;
    end else begin
      remain_r <= remain_nxt;
      pos_r    <= pos_nxt;
      size_r   <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

### src/mmpd_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpd_obuf
// Result register with a skid stage so input can flow while output stalls.
// ----------------------------------------------------------------------------
module mmpd_obuf #(
  parameter int SAMPLE_BITS = mmpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] push_min,
  input  logic [SAMPLE_BITS-1:0] push_max,
  input  logic                   push_last,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_min,
  output logic [SAMPLE_BITS-1:0] out_max,
  output logic                   out_last
);

  localparam int ENT_W = 2 * SAMPLE_BITS + 1;

  logic             out_valid_r, skid_valid_r;
  logic [ENT_W-1:0] out_r, skid_r, push_ent;
  logic             pop;

  assign push_ent = {push_last, push_max, push_min};
  assign pop      = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= push_ent;
      end else begin
        out_r <= push_ent;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_min   = out_r[SAMPLE_BITS-1:0];
  assign out_max   = out_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign out_last  = out_r[ENT_W-1];

endmodule
